FILE: sv/bba_pkg.sv
// shared constants, payload types and control/status bundles for the bitmap allocator
package bba_pkg;

    localparam int MAX_MAPS      = 8;
    localparam int BITS_PER_MAP  = 8192;
    localparam int WORD_BITS     = 32;
    localparam int MAP_WORDS     = MAX_MAPS * BITS_PER_MAP / WORD_BITS;
    localparam int WORDS_PER_MAP = BITS_PER_MAP / WORD_BITS;
    localparam int WORD_AW       = $clog2(MAP_WORDS);
    localparam int BIT_AW        = $clog2(WORD_BITS);
    localparam int IDX_W         = WORD_AW + BIT_AW;
    localparam int WCNT_W        = $clog2(MAP_WORDS + 1);

    localparam int BLK_W      = 16;
    localparam int TOT_W      = 17;
    localparam int MAPS_W     = 4;
    localparam int CALC_W     = 18;
    localparam int BLOCK_SPAN = 65536;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FREE  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_DATA_BLOCK = 2'd0,
        CFG_TOTAL_BLOCKS     = 2'd1,
        CFG_MAPS_IN_USE      = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        command_t          command;
        logic [BLK_W-1:0]  block_number;
    } in_t;

    typedef struct packed {
        logic [BLK_W-1:0]  result_block;
        status_t           status;
    } out_t;

    typedef struct packed {
        logic init_we;
        logic cnt_clr;
        logic cnt_inc;
        logic load_in;
        logic scan_rd;
        logic free_rd;
        logic capture;
        logic alloc_commit;
        logic free_commit;
        logic fail_none;
        logic fail_range;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic scan_more;
        logic rd_vld;
        logic has_clear;
        logic free_in_range;
    } dp_stat_t;

endpackage

FILE: sv/bba_datapath.sv
// bitmap memory, scan counter, config registers, result and output registers
module bba_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data,
    input  bba_pkg::in_t                  s_payload,
    input  bba_pkg::dp_cmd_t              cmd,
    output bba_pkg::dp_stat_t             stat,
    output bba_pkg::out_t                 m_payload
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    logic [BLK_W-1:0]     fdb_reg;
    logic [TOT_W-1:0]     total_reg;
    logic [MAPS_W-1:0]    maps_reg;

    logic [WCNT_W-1:0]    scan_addr_reg;
    logic [BLK_W-1:0]     in_blk_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic [WORD_AW-1:0]   rd_addr_q_reg;
    logic                 rd_vld_reg;
    logic [WORD_BITS-1:0] found_word_reg;
    logic [IDX_W-1:0]     found_idx_reg;
    logic [BLK_W-1:0]     res_block_reg, res_block_next;
    status_t              res_status_reg, res_status_next;
    out_t                 out_reg;

    logic [MAPS_W-1:0]    maps_eff;
    logic [CALC_W-1:0]    limit;
    logic [WCNT_W-1:0]    nwords;
    logic [TOT_W-1:0]     total_eff;
    logic [CALC_W-1:0]    fdb_ext;
    logic [CALC_W-1:0]    total_ext;
    logic [CALC_W-1:0]    blk_ext;
    logic [CALC_W-1:0]    free_idx;
    logic                 free_in_range;
    logic [WORD_AW-1:0]   rd_addr;
    logic [CALC_W-1:0]    idx_ext;
    logic [CALC_W-1:0]    alloc_nb;
    logic                 alloc_ok;
    logic [WORD_BITS-1:0] alloc_word;
    logic                 free_bit;
    logic [WORD_BITS-1:0] free_word;
    logic                 mem_we;
    logic [WORD_AW-1:0]   mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    function automatic logic [BIT_AW-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_AW-1:0] k;
        k = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                k = BIT_AW'(i);
            end
        end
        return k;
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fdb_reg   <= BLK_W'(1);
            total_reg <= TOT_W'(BLOCK_SPAN);
            maps_reg  <= MAPS_W'(MAX_MAPS);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FIRST_DATA_BLOCK: fdb_reg   <= cfg_data[BLK_W-1:0];
                CFG_TOTAL_BLOCKS:     total_reg <= cfg_data[TOT_W-1:0];
                CFG_MAPS_IN_USE:      maps_reg  <= cfg_data[MAPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        maps_eff  = (maps_reg > MAPS_W'(MAX_MAPS)) ? MAPS_W'(MAX_MAPS) : maps_reg;
        limit     = CALC_W'(maps_eff * BITS_PER_MAP);
        nwords    = WCNT_W'(maps_eff * WORDS_PER_MAP);
        total_eff = (total_reg > TOT_W'(BLOCK_SPAN)) ? TOT_W'(BLOCK_SPAN) : total_reg;
        fdb_ext   = CALC_W'(fdb_reg);
        total_ext = CALC_W'(total_eff);
    end

    // free path: range check and bit index
    always_comb begin
        blk_ext       = CALC_W'(in_blk_reg);
        free_idx      = blk_ext - fdb_ext + CALC_W'(1);
        free_in_range = (blk_ext >= fdb_ext) && (blk_ext < total_ext) && (free_idx < limit);
        rd_addr       = cmd.free_rd ? free_idx[IDX_W-1:BIT_AW] : scan_addr_reg[WORD_AW-1:0];
        free_bit      = rdata_reg[free_idx[BIT_AW-1:0]];
        free_word     = rdata_reg & ~(WORD_BITS'(1) << free_idx[BIT_AW-1:0]);
    end

    // allocate path: bound checks on the captured lowest clear bit
    always_comb begin
        idx_ext    = CALC_W'(found_idx_reg);
        alloc_nb   = idx_ext + fdb_ext - CALC_W'(1);
        alloc_ok   = (idx_ext < limit) && (idx_ext != '0) && (alloc_nb < total_ext);
        alloc_word = found_word_reg | (WORD_BITS'(1) << found_idx_reg[BIT_AW-1:0]);
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = scan_addr_reg[WORD_AW-1:0];
        mem_wdata = '0;
        if (cmd.init_we) begin
            mem_we    = 1'b1;
            mem_wdata = (scan_addr_reg == '0) ? WORD_BITS'(1) : '0;
        end else if (cmd.alloc_commit && alloc_ok) begin
            mem_we    = 1'b1;
            mem_waddr = found_idx_reg[IDX_W-1:BIT_AW];
            mem_wdata = alloc_word;
        end else if (cmd.free_commit && free_bit) begin
            mem_we    = 1'b1;
            mem_waddr = free_idx[IDX_W-1:BIT_AW];
            mem_wdata = free_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg     <= mem[rd_addr];
        rd_addr_q_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_rd | cmd.free_rd;
            if (cmd.cnt_clr) begin
                scan_addr_reg <= '0;
            end else if (cmd.cnt_inc) begin
                scan_addr_reg <= scan_addr_reg + WCNT_W'(1);
            end
        end
    end

    always_comb begin
        res_block_next  = res_block_reg;
        res_status_next = res_status_reg;
        if (cmd.fail_none) begin
            res_block_next  = '0;
            res_status_next = ST_NONE;
        end else if (cmd.fail_range) begin
            res_block_next  = in_blk_reg;
            res_status_next = ST_RANGE;
        end else if (cmd.alloc_commit) begin
            res_block_next  = alloc_ok ? alloc_nb[BLK_W-1:0] : '0;
            res_status_next = alloc_ok ? ST_OK : ST_NONE;
        end else if (cmd.free_commit) begin
            res_block_next  = in_blk_reg;
            res_status_next = free_bit ? ST_OK : ST_FREE;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_blk_reg <= s_payload.block_number;
        end
        if (cmd.capture) begin
            found_word_reg <= rdata_reg;
            found_idx_reg  <= {rd_addr_q_reg, lowest_zero(rdata_reg)};
        end
        res_block_reg  <= res_block_next;
        res_status_reg <= res_status_next;
        if (cmd.load_out) begin
            out_reg.result_block <= res_block_reg;
            out_reg.status       <= res_status_reg;
        end
    end

    assign stat.sweep_last    = (scan_addr_reg == WCNT_W'(MAP_WORDS - 1));
    assign stat.scan_more     = (scan_addr_reg < nwords);
    assign stat.rd_vld        = rd_vld_reg;
    assign stat.has_clear     = ~&rdata_reg;
    assign stat.free_in_range = free_in_range;
    assign m_payload          = out_reg;

    // the reserved bit never gets cleared once the sweep is done
    a_reserved_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && !cmd.init_we) |-> ((mem_waddr != '0) || mem_wdata[0]))
        else $error("reserved bit cleared");

    a_capture_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> !found_word_reg[found_idx_reg[BIT_AW-1:0]])
        else $error("captured bit is not clear");

    a_alloc_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.alloc_commit && alloc_ok) |-> (alloc_nb >= fdb_ext) && (alloc_nb < total_ext))
        else $error("allocated block outside data zone");

endmodule

FILE: sv/bba_ctrl.sv
// controller state machine: clear sweep, scan sequencing, free check, result handoff
module bba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bba_pkg::command_t   s_command,
    output logic                m_valid,
    input  logic                m_ready,
    input  bba_pkg::dp_stat_t   stat,
    output bba_pkg::dp_cmd_t    cmd
);
    import bba_pkg::*;

    typedef enum logic [6:0] {
        S_INIT     = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_ALLOC    = 7'b0001000,
        S_FREE_RD  = 7'b0010000,
        S_FREE_CHK = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg & ~m_ready;
        unique case (state_reg)
            S_INIT: begin
                cmd.init_we = 1'b1;
                if (stat.sweep_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    state_next  = (s_command == CMD_FREE) ? S_FREE_RD : S_SCAN;
                end
            end
            S_SCAN: begin
                // one word read issued per cycle while words remain, data checked in the next cycle
                cmd.scan_rd = stat.scan_more;
                cmd.cnt_inc = stat.scan_more;
                if (stat.rd_vld && stat.has_clear) begin
                    cmd.capture = 1'b1;
                    state_next  = S_ALLOC;
                end else if (!stat.scan_more && !stat.rd_vld) begin
                    cmd.fail_none = 1'b1;
                    state_next    = S_RESP;
                end
            end
            S_ALLOC: begin
                cmd.alloc_commit = 1'b1;
                state_next       = S_RESP;
            end
            S_FREE_RD: begin
                if (stat.free_in_range) begin
                    cmd.free_rd = 1'b1;
                    state_next  = S_FREE_CHK;
                end else begin
                    cmd.fail_range = 1'b1;
                    state_next     = S_RESP;
                end
            end
            S_FREE_CHK: begin
                cmd.free_commit = 1'b1;
                state_next      = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted while busy");

    a_sweep_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.init_we |-> (!cmd.scan_rd && !cmd.free_rd && !s_ready && !cmd.load_out))
        else $error("activity during clear sweep");

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before taken");

endmodule

FILE: sv/block_bitmap_allocator.sv
// top level of the first-fit block bitmap allocator
// after reset a clear pass writes all 2048 bitmap words, one per cycle; no transaction
// is taken during the pass, configuration writes are taken at all times
// allocate: words are read one at a time through the single read port of the bitmap
// memory, up to 2048, until the first word with a clear bit; that bit is then set
// free: range check and read, then bit check and clear; one transaction in flight
// reset is synchronous active low and restores config defaults and an empty map
module block_bitmap_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bba_pkg::in_t                   s_payload,
    output logic                           m_valid,
    input  logic                           m_ready,
    output bba_pkg::out_t                  m_payload,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bba_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     cfg_we;

    // config registers take a write in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    bba_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_payload.command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bba_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_payload (m_payload)
    );

endmodule
